>>> sv/lcd4_pkg.sv
// Shared types and constants for the 4-bit character LCD interface.
// Holds the microcode word layout, opcode enums, hold times and request codes.
// No dependencies.
`timescale 1ns / 1ps

package lcd4_pkg;

    // Request mode codes.
    localparam logic [2:0] MODE_INIT = 3'd0;
    localparam logic [2:0] MODE_CMD  = 3'd1;
    localparam logic [2:0] MODE_DATA = 3'd2;
    localparam logic [2:0] MODE_CURS = 3'd3;
    localparam logic [2:0] MODE_ADDR = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_FUNC_SET = 2'd0;
    localparam logic [1:0] REG_ENTRY    = 2'd1;
    localparam logic [1:0] REG_DISPLAY  = 2'd2;

    // Register reset values.
    localparam logic [7:0] FUNC_SET_RST = 8'h28;
    localparam logic [7:0] ENTRY_RST    = 8'h06;
    localparam logic [7:0] DISPLAY_RST  = 8'h0F;

    // Fixed command bytes and address bases.
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;
    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [3:0] WAKE_NIB  = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

    // Hold times in microseconds.
    localparam logic [14:0] HOLD_SETUP   = 15'd5;
    localparam logic [14:0] HOLD_PULSE   = 15'd10;
    localparam logic [14:0] HOLD_GAP     = 15'd100;
    localparam logic [14:0] HOLD_SETTLE  = 15'd1100;
    localparam logic [14:0] HOLD_LONG    = 15'd2100;
    localparam logic [14:0] HOLD_POWERUP = 15'd30000;

    // Microprogram layout.
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] INIT_ENTRY = 6'd0;
    localparam logic [PC_W-1:0] BYTE_ENTRY = 6'd42;
    localparam logic [PC_W-1:0] LAST_ADDR  = 6'd48;

    typedef enum logic [1:0] {SEL_KEEP, SEL_CMD, SEL_REQ} sel_op_t;
    typedef enum logic [1:0] {EN_KEEP, EN_CLR, EN_SET} en_op_t;
    typedef enum logic [2:0] {NIB_KEEP, NIB_WAKE, NIB_FOUR, NIB_HI, NIB_LO} nib_op_t;
    typedef enum logic [2:0] {SRC_REQ, SRC_FUNC, SRC_ENTRY, SRC_DISP, SRC_CLEAR} src_t;
    typedef enum logic [2:0] {
        H_SETUP, H_PULSE, H_GAP, H_SETTLE, H_LONG, H_POWERUP, H_REQ_SETTLE
    } hold_t;

    // One control word: drives one output segment.
    typedef struct packed {
        sel_op_t sel;
        en_op_t  en;
        nib_op_t nib;
        src_t    src;
        hold_t   hold;
        logic    last;
    } ucode_t;

    // Latched request: the byte to send, its RS level and its settle length.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       rs;
        logic       long_settle;
    } req_t;

    // Init command registers.
    typedef struct packed {
        logic [7:0] func_set;
        logic [7:0] entry;
        logic [7:0] display;
    } cfg_t;

endpackage

>>> sv/char_lcd_4bit_interface.sv
// Top level of the 4-bit character LCD interface: sequencer, config registers.
// Depends on lcd4_pkg, lcd4_ucode_rom and lcd4_pin_datapath.
//
//   channel   direction  handshake              beat
//   request   in         in_valid / in_stall    mode, byte_value, column, row, ddram_address
//   segment   out        out_valid / out_stall  rs_pin, enable_pin, data_nibble, hold_us,
//                                               last_segment
//   config    in         write_enable           register_index, write_data
//
// One segment leaves per cycle while the output is not stalled. A byte request loads the
// step counter, then sends seven segments while the input stays stalled; init sends 42.
// A request with no segments (row above one, unknown mode) is taken without going busy.
// Requests are accepted only while the sequencer is idle; a stalled output holds the
// step counter. Reset clears the pin levels and loads the register defaults.
`timescale 1ns / 1ps

module char_lcd_4bit_interface (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [5:0]  column,
    input  logic [1:0]  row,
    input  logic [6:0]  ddram_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rs_pin,
    output logic        enable_pin,
    output logic [3:0]  data_nibble,
    output logic [14:0] hold_us,
    output logic        last_segment,
    input  logic        write_enable,
    input  logic [1:0]  register_index,
    input  logic [7:0]  write_data
);
    import lcd4_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    req_t            req_reg, req_next;
    cfg_t            cfg_reg;
    ucode_t          ctrl;
    logic            accept, start, step, load_ok;
    logic [PC_W-1:0] start_pc;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !in_stall;
    assign step     = busy_reg && load_ok;

    // Decode a request into a start address and the byte to send.
    always_comb
    begin
        start    = 1'b1;
        start_pc = BYTE_ENTRY;
        req_next = req_reg;
        unique case (mode)
            MODE_INIT:
            begin
                start_pc = INIT_ENTRY;
            end
            MODE_CMD:
            begin
                req_next.byte_val    = byte_value;
                req_next.rs          = 1'b0;
                req_next.long_settle = (byte_value == CMD_CLEAR) || (byte_value == CMD_HOME);
            end
            MODE_DATA:
            begin
                req_next.byte_val    = byte_value;
                req_next.rs          = 1'b1;
                req_next.long_settle = 1'b0;
            end
            MODE_CURS:
            begin
                req_next.byte_val    = (row[0] ? ROW1_BASE : ROW0_BASE) + {2'b00, column};
                req_next.rs          = 1'b0;
                req_next.long_settle = 1'b0;
                start                = !row[1];
            end
            MODE_ADDR:
            begin
                req_next.byte_val    = DDRAM_SET + {1'b0, ddram_address};
                req_next.rs          = 1'b0;
                req_next.long_settle = 1'b0;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    // Step counter: load on a request, advance per segment, stop on the last word.
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = start;
            pc_next   = start_pc;
        end
        else if (step)
        begin
            busy_next = !ctrl.last;
            pc_next   = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= INIT_ENTRY;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    // Init command registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.func_set <= FUNC_SET_RST;
            cfg_reg.entry    <= ENTRY_RST;
            cfg_reg.display  <= DISPLAY_RST;
        end
        else if (write_enable)
        begin
            if (register_index == REG_FUNC_SET)
            begin
                cfg_reg.func_set <= write_data;
            end
            if (register_index == REG_ENTRY)
            begin
                cfg_reg.entry <= write_data;
            end
            if (register_index == REG_DISPLAY)
            begin
                cfg_reg.display <= write_data;
            end
        end
    end

    lcd4_ucode_rom u_rom (
        .addr (pc_reg),
        .ctrl (ctrl)
    );

    lcd4_pin_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ctrl         (ctrl),
        .req          (req_reg),
        .cfg          (cfg_reg),
        .out_stall    (out_stall),
        .load_ok      (load_ok),
        .out_valid    (out_valid),
        .rs_pin       (rs_pin),
        .enable_pin   (enable_pin),
        .data_nibble  (data_nibble),
        .hold_us      (hold_us),
        .last_segment (last_segment)
    );

`ifndef SYNTH
    // The step counter never runs past the program while busy.
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> pc_reg <= LAST_ADDR)
        else $error("step counter beyond microprogram");

    // The final control word returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n) step && ctrl.last |=> !busy_reg)
        else $error("sequencer still busy after last segment");

    // A byte request starts at the byte program entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_DATA) |=> busy_reg && (pc_reg == BYTE_ENTRY))
        else $error("data request did not start byte program");

    // A segment is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hold_us))
        else $error("output segment overwritten while stalled");
`endif

endmodule

>>> sv/lcd4_ucode_rom.sv
// Microcode store for the LCD sequencer: init program and byte program.
// Depends on lcd4_pkg.
`timescale 1ns / 1ps

module lcd4_ucode_rom (
    input  logic [lcd4_pkg::PC_W-1:0] addr,
    output lcd4_pkg::ucode_t          ctrl
);
    import lcd4_pkg::*;

    function automatic ucode_t mk(sel_op_t s, en_op_t e, nib_op_t n, src_t b,
                                  hold_t h, logic l);
        ucode_t w;
        w.sel  = s;
        w.en   = e;
        w.nib  = n;
        w.src  = b;
        w.hold = h;
        w.last = l;
        return w;
    endfunction

    // Init occupies steps 0 to 41, a single byte steps 42 to 48.
    always_comb
    begin
        unique case (addr)
            6'd0:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_KEEP, SRC_REQ, H_POWERUP, 1'b0);
            6'd1:
                ctrl = mk(SEL_CMD, EN_SET, NIB_KEEP, SRC_REQ, H_SETUP, 1'b0);
            6'd2, 6'd5, 6'd8:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_WAKE, SRC_REQ, H_PULSE, 1'b0);
            6'd11:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_FOUR, SRC_REQ, H_PULSE, 1'b0);
            6'd3, 6'd6, 6'd9, 6'd12, 6'd16, 6'd19, 6'd23, 6'd26, 6'd30, 6'd33,
            6'd37, 6'd40, 6'd44, 6'd47:
                ctrl = mk(SEL_KEEP, EN_CLR, NIB_KEEP, SRC_REQ, H_GAP, 1'b0);
            6'd4, 6'd7, 6'd10, 6'd13:
                ctrl = mk(SEL_KEEP, EN_SET, NIB_KEEP, SRC_REQ, H_LONG, 1'b0);
            6'd14, 6'd21, 6'd28, 6'd35:
                ctrl = mk(SEL_CMD, EN_KEEP, NIB_KEEP, SRC_REQ, H_SETUP, 1'b0);
            6'd15:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_HI, SRC_FUNC, H_PULSE, 1'b0);
            6'd18:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_LO, SRC_FUNC, H_PULSE, 1'b0);
            6'd22:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_HI, SRC_ENTRY, H_PULSE, 1'b0);
            6'd25:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_LO, SRC_ENTRY, H_PULSE, 1'b0);
            6'd29:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_HI, SRC_DISP, H_PULSE, 1'b0);
            6'd32:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_LO, SRC_DISP, H_PULSE, 1'b0);
            6'd36:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_HI, SRC_CLEAR, H_PULSE, 1'b0);
            6'd39:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_LO, SRC_CLEAR, H_PULSE, 1'b0);
            6'd17, 6'd24, 6'd31, 6'd38, 6'd45:
                ctrl = mk(SEL_KEEP, EN_SET, NIB_KEEP, SRC_REQ, H_GAP, 1'b0);
            6'd20, 6'd27, 6'd34:
                ctrl = mk(SEL_KEEP, EN_SET, NIB_KEEP, SRC_REQ, H_SETTLE, 1'b0);
            6'd41:
                ctrl = mk(SEL_KEEP, EN_SET, NIB_KEEP, SRC_REQ, H_LONG, 1'b1);
            6'd42:
                ctrl = mk(SEL_REQ, EN_KEEP, NIB_KEEP, SRC_REQ, H_SETUP, 1'b0);
            6'd43:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_HI, SRC_REQ, H_PULSE, 1'b0);
            6'd46:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_LO, SRC_REQ, H_PULSE, 1'b0);
            6'd48:
                ctrl = mk(SEL_KEEP, EN_SET, NIB_KEEP, SRC_REQ, H_REQ_SETTLE, 1'b1);
            // Addresses past the program end the run safely.
            default:
                ctrl = mk(SEL_KEEP, EN_KEEP, NIB_KEEP, SRC_REQ, H_SETUP, 1'b1);
        endcase
    end

endmodule

>>> sv/lcd4_pin_datapath.sv
// Pin datapath: holds the RS, E and nibble levels and the output segment register.
// Depends on lcd4_pkg; driven by the control word of lcd4_ucode_rom.
`timescale 1ns / 1ps

module lcd4_pin_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  lcd4_pkg::ucode_t ctrl,
    input  lcd4_pkg::req_t   req,
    input  lcd4_pkg::cfg_t   cfg,
    input  logic             out_stall,
    output logic             load_ok,
    output logic             out_valid,
    output logic             rs_pin,
    output logic             enable_pin,
    output logic [3:0]       data_nibble,
    output logic [14:0]      hold_us,
    output logic             last_segment
);
    import lcd4_pkg::*;

    logic        sel_reg, sel_next;
    logic        en_reg, en_next;
    logic [3:0]  nib_reg, nib_next;
    logic        out_valid_reg, out_valid_next;
    logic        rs_out_reg, en_out_reg, last_out_reg;
    logic [3:0]  nib_out_reg;
    logic [14:0] hold_out_reg;
    logic [14:0] hold_val;
    logic [7:0]  src_byte;

    // The output register can take a new segment when empty or being drained.
    assign load_ok = !out_valid_reg || !out_stall;

    // Byte source for the nibble being clocked.
    always_comb
    begin
        unique case (ctrl.src)
            SRC_FUNC:  src_byte = cfg.func_set;
            SRC_ENTRY: src_byte = cfg.entry;
            SRC_DISP:  src_byte = cfg.display;
            SRC_CLEAR: src_byte = CMD_CLEAR;
            default:   src_byte = req.byte_val;
        endcase
    end

    // Pin levels after this step's control word.
    always_comb
    begin
        unique case (ctrl.sel)
            SEL_CMD: sel_next = 1'b0;
            SEL_REQ: sel_next = req.rs;
            default: sel_next = sel_reg;
        endcase
        unique case (ctrl.en)
            EN_CLR:  en_next = 1'b0;
            EN_SET:  en_next = 1'b1;
            default: en_next = en_reg;
        endcase
        unique case (ctrl.nib)
            NIB_WAKE: nib_next = WAKE_NIB;
            NIB_FOUR: nib_next = FOUR_BIT_NIB;
            NIB_HI:   nib_next = src_byte[7:4];
            NIB_LO:   nib_next = src_byte[3:0];
            default:  nib_next = nib_reg;
        endcase
    end

    // Hold time of this segment.
    always_comb
    begin
        unique case (ctrl.hold)
            H_SETUP:      hold_val = HOLD_SETUP;
            H_PULSE:      hold_val = HOLD_PULSE;
            H_GAP:        hold_val = HOLD_GAP;
            H_SETTLE:     hold_val = HOLD_SETTLE;
            H_LONG:       hold_val = HOLD_LONG;
            H_POWERUP:    hold_val = HOLD_POWERUP;
            H_REQ_SETTLE: hold_val = req.long_settle ? HOLD_LONG : HOLD_SETTLE;
            default:      hold_val = HOLD_SETUP;
        endcase
    end

    assign out_valid_next = step ? 1'b1 : (out_valid_reg && out_stall);

    // Pin state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            en_reg        <= 1'b0;
            nib_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                sel_reg <= sel_next;
                en_reg  <= en_next;
                nib_reg <= nib_next;
            end
        end
    end

    // Output segment payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rs_out_reg   <= sel_next;
            en_out_reg   <= en_next;
            nib_out_reg  <= nib_next;
            hold_out_reg <= hold_val;
            last_out_reg <= ctrl.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rs_pin       = rs_out_reg;
    assign enable_pin   = en_out_reg;
    assign data_nibble  = nib_out_reg;
    assign hold_us      = hold_out_reg;
    assign last_segment = last_out_reg;

endmodule

>>> dv/char_lcd_4bit_interface_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_4bit_interface: a directed request table, then
// random requests under random stalls, every segment compared with a behavioral predictor.
// Depends on lcd4_pkg and the char_lcd_4bit_interface RTL.

module char_lcd_4bit_interface_test;
    import lcd4_pkg::*;

    localparam int CYCLE_LIMIT     = 5000000;
    localparam int RANDOM_ITEMS    = 256;
    localparam int PHASES          = 5;
    localparam int IDLE_CYCLES     = 4;
    localparam int TAIL_CYCLES     = 50;
    localparam int HOLD_OFF_CYCLES = 400;

    // Pin timing in microseconds.
    localparam int US_SETUP   = 5;
    localparam int US_PULSE   = 10;
    localparam int US_GAP     = 100;
    localparam int US_SETTLE  = 1000;
    localparam int US_WAKE    = 2000;
    localparam int US_POWERUP = 30000;

    // LCD command bytes, address bases and init nibbles.
    localparam logic [7:0] CLEAR_BYTE    = 8'h01;
    localparam logic [7:0] HOME_BYTE     = 8'h02;
    localparam logic [7:0] BASE_ROW0     = 8'h80;
    localparam logic [7:0] BASE_ROW1     = 8'hC0;
    localparam logic [7:0] BASE_DDRAM    = 8'h80;
    localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
    localparam logic [3:0] SWITCH_NIBBLE = 4'h2;

    // Codes the block has no use for.
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    // One pin segment as it leaves the block.
    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [14:0] hold;
        logic        last;
    } lcd_seg_t;

    // One request; segs and end_hold are typed-in expectations, zero where not given.
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  value;
        logic [5:0]  col;
        logic [1:0]  row;
        logic [6:0]  addr;
        logic [5:0]  segs;
        logic [14:0] end_hold;
    } lcd_req_t;

    typedef struct packed {
        logic [5:0]  segs;
        logic [14:0] end_hold;
    } run_end_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = MODE_INIT;
    logic [7:0]  byte_value = 8'h00;
    logic [5:0]  column = 6'd0;
    logic [1:0]  row = 2'd0;
    logic [6:0]  ddram_address = 7'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        rs_pin;
    logic        enable_pin;
    logic [3:0]  data_nibble;
    logic [14:0] hold_us;
    logic        last_segment;
    logic        write_enable = 1'b0;
    logic [1:0]  register_index = REG_FUNC_SET;
    logic [7:0]  write_data = 8'h00;

    // Typed-in expectation that travels with the request on the input.
    logic [5:0]  plan_segs = 6'd0;
    logic [14:0] plan_hold = 15'd0;

    // Predicted register contents and pin levels.
    logic [7:0] cfg_func = 8'h28;
    logic [7:0] cfg_entry = 8'h06;
    logic [7:0] cfg_disp = 8'h0F;
    logic [3:0] pin_nibble = 4'h0;
    logic       pin_enable = 1'b0;
    logic       pin_select = 1'b0;

    lcd_seg_t segments_due[$];
    run_end_t run_ends_due[$];

    int  errors = 0;
    int  cycles = 0;
    int  requests_done = 0;
    int  inits_done = 0;
    int  ignored_done = 0;
    int  segs_checked = 0;
    int  run_len = 0;
    int  hold_off_asks = 0;
    bit  quiet = 1'b0;

    char_lcd_4bit_interface uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .byte_value     (byte_value),
        .column         (column),
        .row            (row),
        .ddram_address  (ddram_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rs_pin         (rs_pin),
        .enable_pin     (enable_pin),
        .data_nibble    (data_nibble),
        .hold_us        (hold_us),
        .last_segment   (last_segment),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor: the current pin levels held for the given time.
    function automatic void drive_segment(input int hold);
        segments_due.push_back(lcd_seg_t'{pin_select, pin_enable, pin_nibble, 15'(hold), 1'b0});
    endfunction

    // One nibble: E held, E low (the LCD latches here), then E high with extra settle.
    function automatic void strobe_nibble(input logic [3:0] nib, input int extra);
        pin_nibble = nib;
        drive_segment(US_PULSE);
        pin_enable = 1'b0;
        drive_segment(US_GAP);
        pin_enable = 1'b1;
        drive_segment(US_GAP + extra);
    endfunction

    function automatic void send_lcd_byte(input logic rs, input logic [7:0] b, input int settle);
        pin_select = rs;
        drive_segment(US_SETUP);
        strobe_nibble(b[7:4], 0);
        strobe_nibble(b[3:0], settle);
    endfunction

    // Expands one request into its pin segments and returns how many it made.
    function automatic int expand_request(input lcd_req_t r);
        int       first;
        lcd_seg_t tail;
        first = segments_due.size();
        case (r.mode)
            MODE_INIT:
            begin
                drive_segment(US_POWERUP);
                pin_enable = 1'b1;
                pin_select = 1'b0;
                drive_segment(US_SETUP);
                repeat (3) strobe_nibble(WAKE_NIBBLE, US_WAKE);
                strobe_nibble(SWITCH_NIBBLE, US_WAKE);
                send_lcd_byte(1'b0, cfg_func, US_SETTLE);
                send_lcd_byte(1'b0, cfg_entry, US_SETTLE);
                send_lcd_byte(1'b0, cfg_disp, US_SETTLE);
                send_lcd_byte(1'b0, CLEAR_BYTE, 2 * US_SETTLE);
            end
            MODE_CMD:
                send_lcd_byte(1'b0, r.value,
                              (r.value == CLEAR_BYTE || r.value == HOME_BYTE) ?
                              2 * US_SETTLE : US_SETTLE);
            MODE_DATA:
                send_lcd_byte(1'b1, r.value, US_SETTLE);
            MODE_CURS:
            begin
                if (r.row == 2'd0)
                    send_lcd_byte(1'b0, BASE_ROW0 + r.col, US_SETTLE);
                else if (r.row == 2'd1)
                    send_lcd_byte(1'b0, BASE_ROW1 + r.col, US_SETTLE);
            end
            MODE_ADDR:
                send_lcd_byte(1'b0, BASE_DDRAM + r.addr, US_SETTLE);
            default:
                ;
        endcase
        if (segments_due.size() > first)
        begin
            tail = segments_due.pop_back();
            tail.last = 1'b1;
            segments_due.push_back(tail);
        end
        return segments_due.size() - first;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic lcd_req_t request_of(input logic [2:0] m, input logic [7:0] v,
                                            input logic [5:0] c, input logic [1:0] rw,
                                            input logic [6:0] a, input logic [5:0] n,
                                            input logic [14:0] h);
        return '{m, v, c, rw, a, n, h};
    endfunction

    // Mostly byte requests, some inits, some rows above one and spare modes.
    function automatic lcd_req_t random_request();
        int       pick;
        lcd_req_t r;
        pick = $urandom_range(0, 99);
        r = request_of(MODE_DATA, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                       2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), 6'd0, 15'd0);
        if (pick < 6)
            r.mode = MODE_INIT;
        else if (pick < 30)
        begin
            r.mode = MODE_CMD;
            if ($urandom_range(0, 4) == 0)
                r.value = 8'($urandom_range(CLEAR_BYTE, HOME_BYTE));
        end
        else if (pick < 58)
            r.mode = MODE_DATA;
        else if (pick < 78)
        begin
            r.mode = MODE_CURS;
            if ($urandom_range(0, 4) != 0)
                r.row = 2'($urandom_range(0, 1));
        end
        else if (pick < 96)
            r.mode = MODE_ADDR;
        else
            r.mode = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request beat and returns at the edge that accepts it.
    task automatic offer(input lcd_req_t r, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= r.mode;
        byte_value    <= r.value;
        column        <= r.col;
        row           <= r.row;
        ddram_address <= r.addr;
        plan_segs     <= r.segs;
        plan_hold     <= r.end_hold;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stops offering and waits until every expected segment has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (segments_due.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_registers(input logic [7:0] f, input logic [7:0] e,
                                  input logic [7:0] d, input bit touch_unused);
        drain();
        write_enable   <= 1'b1;
        register_index <= REG_FUNC_SET;
        write_data     <= f;
        cfg_func = f;
        @(posedge clk);
        register_index <= REG_ENTRY;
        write_data     <= e;
        cfg_entry = e;
        @(posedge clk);
        register_index <= REG_DISPLAY;
        write_data     <= d;
        cfg_disp = d;
        @(posedge clk);
        // An index with no register behind it must change nothing.
        if (touch_unused)
        begin
            register_index <= REG_UNUSED;
            write_data     <= ~f;
            @(posedge clk);
        end
        write_enable <= 1'b0;
    endtask

    // Predict on each accepted request, compare each accepted segment.
    always @(posedge clk)
    begin
        lcd_seg_t want;
        run_end_t known;
        int       produced;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                produced = expand_request(request_of(mode, byte_value, column, row,
                                                     ddram_address, plan_segs, plan_hold));
                if (produced > 0)
                begin
                    run_ends_due.push_back('{plan_segs, plan_hold});
                    requests_done++;
                    if (mode == MODE_INIT)
                        inits_done++;
                end
                else
                    ignored_done++;
            end
            if (out_valid && !out_stall)
            begin
                if (segments_due.size() == 0)
                begin
                    $error("segment with none expected: rs=%0b e=%0b nibble=%0h hold=%0d",
                           rs_pin, enable_pin, data_nibble, hold_us);
                    errors++;
                end
                else
                begin
                    want = segments_due.pop_front();
                    check_field("rs_pin", want.rs, rs_pin);
                    check_field("enable_pin", want.en, enable_pin);
                    check_field("data_nibble", want.nib, data_nibble);
                    check_field("hold_us", want.hold, hold_us);
                    check_field("last_segment", want.last, last_segment);
                    segs_checked++;
                    run_len++;
                    // Typed-in run length and final hold, where the table gives them.
                    if (last_segment)
                    begin
                        if (run_ends_due.size() != 0)
                        begin
                            known = run_ends_due.pop_front();
                            if (known.segs != 0)
                            begin
                                check_field("segment count", known.segs, run_len);
                                check_field("final hold_us", known.end_hold, hold_us);
                            end
                        end
                        run_len = 0;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        int rx_gap;
        int rx_run;
        int hold_left;
        int asks_seen;
        if (hold_off_asks != asks_seen)
        begin
            asks_seen = hold_off_asks;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else if (rx_run > 0)
        begin
            rx_run--;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= 1'b0;
            rx_run = $urandom_range(0, 15);
            rx_gap = idle_gap();
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        lcd_req_t plan[$];
        lcd_req_t r;
        int       phase;
        int       made;
        bit       held_off;
        bit       paused;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: mode, byte, column, row, address, segments, final hold.
        plan = '{
            request_of(MODE_INIT,    8'h00,  0, 0,   0, 42, 2100),
            request_of(MODE_CMD,     8'h00,  0, 0,   0,  7, 1100),
            request_of(MODE_CMD,     8'hFF, 63, 3, 127,  7, 1100),
            request_of(MODE_CMD,     8'h01,  0, 0,   0,  7, 2100),
            request_of(MODE_CMD,     8'h02, 63, 3, 127,  7, 2100),
            request_of(MODE_CMD,     8'h03,  0, 0,   0,  7, 1100),
            request_of(MODE_DATA,    8'h00,  0, 0,   0,  7, 1100),
            request_of(MODE_DATA,    8'hFF, 63, 3, 127,  7, 1100),
            request_of(MODE_DATA,    8'h01,  0, 0,   0,  7, 1100),
            request_of(MODE_DATA,    8'hA5,  0, 0,   0,  0,    0),
            request_of(MODE_DATA,    8'h5A, 42, 2,  85,  0,    0),
            request_of(MODE_CURS,    8'h00,  0, 0,   0,  7, 1100),
            request_of(MODE_CURS,    8'hFF, 63, 0, 127,  0,    0),
            request_of(MODE_CURS,    8'h00,  0, 1,   0,  7, 1100),
            request_of(MODE_CURS,    8'h00, 63, 1,   0,  0,    0),
            request_of(MODE_CURS,    8'h00,  5, 2,   0,  0,    0),
            request_of(MODE_CURS,    8'hFF, 63, 3, 127,  0,    0),
            request_of(MODE_ADDR,    8'h00,  0, 0,   0,  7, 1100),
            request_of(MODE_ADDR,    8'h00,  0, 0, 127,  0,    0),
            request_of(MODE_ADDR,    8'hFF, 63, 3,  42,  0,    0),
            request_of(MODE_SPARE_5, 8'h00,  0, 0,   0,  0,    0),
            request_of(MODE_SPARE_6, 8'h02,  1, 1,   1,  0,    0),
            request_of(MODE_SPARE_7, 8'hFF, 63, 3, 127,  0,    0),
            request_of(MODE_INIT,    8'hFF, 63, 3, 127, 42, 2100)
        };
        foreach (plan[i])
            offer(plan[i], idle_gap());

        held_off = 1'b0;
        paused = 1'b0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: load_registers(8'h00, 8'h00, 8'h00, 1'b1);
                1: load_registers(8'hFF, 8'hFF, 8'hFF, 1'b0);
                // Clear and home as init commands still get the normal settle.
                4: load_registers(CLEAR_BYTE, HOME_BYTE, CLEAR_BYTE, 1'b1);
                default: load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)), 1'b0);
            endcase
            // One phase runs back to back with no idling on either side.
            quiet = (phase == 2);
            made = 0;
            while (made < RANDOM_ITEMS / PHASES)
            begin
                r = random_request();
                // Receiver holds off while the sender keeps offering back to back.
                if (phase == 1 && made == 10 && !held_off)
                begin
                    held_off = 1'b1;
                    hold_off_asks++;
                end
                if (phase == 3 && made == 20 && !paused)
                begin
                    paused = 1'b1;
                    drain();
                end
                offer(r, (phase == 1 && made >= 10 && made < 22) ? 0 : idle_gap());
                if (r.mode <= MODE_ADDR && !(r.mode == MODE_CURS && r.row > 2'd1))
                    made++;
            end
        end
        quiet = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d segments from %0d requests (%0d init), %0d requests ignored.",
                 segs_checked, requests_done, inits_done, ignored_done);
        $display("Init registers ran at reset values, all zeros, all ones, random and clear/home.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
